[rtl/core/threefold_quadratic_densifier_macros.svh]
// Assertion macros for the densifier RTL.
`ifndef THREEFOLD_QUADRATIC_DENSIFIER_MACROS_SVH
`define THREEFOLD_QUADRATIC_DENSIFIER_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define TQD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition implies a property in the same cycle.
`define TQD_ASSERT_IMPL(label, cond, prop, msg) \
   `TQD_ASSERT(label, (cond) |-> (prop), msg)

`endif

[rtl/core/tqd_pkg.sv]
// Types, step codes and interpolation weights of the threefold quadratic densifier.
`default_nettype none

package tqd_pkg;

   localparam int WEIGHT_BITS = 5;

   typedef logic [2:0] step_type;
   typedef logic [1:0] seen_type;

   localparam step_type STEP_OLDER   = 3'd0;
   localparam step_type STEP_FIRST   = 3'd1;
   localparam step_type STEP_SECOND  = 3'd2;
   localparam step_type STEP_NEWER   = 3'd3;
   localparam step_type STEP_THIRD   = 3'd4;
   localparam step_type STEP_FOURTH  = 3'd5;
   localparam step_type STEP_CURRENT = 3'd6;

   localparam step_type LAST_SHORT = STEP_OLDER;
   localparam step_type LAST_RUN   = STEP_SECOND;
   localparam step_type LAST_TABLE = STEP_CURRENT;

   localparam seen_type SEEN_NONE = 2'd0;
   localparam seen_type SEEN_FULL = 2'd2;

   typedef struct packed {
      logic [WEIGHT_BITS-1:0] w0;
      logic [WEIGHT_BITS-1:0] w1;
      logic [WEIGHT_BITS-1:0] w2;
   } weight_set_type;

   // Weights in ninths; a plain sample is passed as nine ninths of itself.
   function automatic weight_set_type weights_for(input step_type step);
      weight_set_type ws;
      case (step)
         STEP_OLDER: begin
            ws = '{WEIGHT_BITS'(9), WEIGHT_BITS'(0), WEIGHT_BITS'(0)};
         end
         STEP_FIRST: begin
            ws = '{WEIGHT_BITS'(5), WEIGHT_BITS'(5), WEIGHT_BITS'(-1)};
         end
         STEP_SECOND: begin
            ws = '{WEIGHT_BITS'(2), WEIGHT_BITS'(8), WEIGHT_BITS'(-1)};
         end
         STEP_NEWER: begin
            ws = '{WEIGHT_BITS'(0), WEIGHT_BITS'(9), WEIGHT_BITS'(0)};
         end
         STEP_THIRD: begin
            ws = '{WEIGHT_BITS'(-1), WEIGHT_BITS'(8), WEIGHT_BITS'(2)};
         end
         STEP_FOURTH: begin
            ws = '{WEIGHT_BITS'(-1), WEIGHT_BITS'(5), WEIGHT_BITS'(5)};
         end
         STEP_CURRENT: begin
            ws = '{WEIGHT_BITS'(0), WEIGHT_BITS'(0), WEIGHT_BITS'(9)};
         end
         default: begin
            ws = '0;
         end
      endcase
      return ws;
   endfunction

endpackage

`default_nettype wire

[rtl/core/threefold_quadratic_densifier.sv]
// Top level of the threefold quadratic densifier.
// The req channel takes one signed sample per transaction in req_tdata, with
// req_tlast marking the last sample of a table. The rsp channel returns the
// densified table, one value per transaction: req_tdata and rsp_tdata carry a
// SAMPLE_BITS value in their low bits, rsp_tuser carries status (bit 0, set for
// a table shorter than three samples) and run_end (bit 1, set on the last
// result of a sample), and rsp_tlast marks the last result of the table.
// The first two samples of a table give no result. Each later sample gives
// three results and the final one seven, one result per clock unless
// rsp_tready stalls; a final sample after fewer than two samples gives a
// single result with status set. A sample's first result passes the job,
// weighted-sum and output registers before it shows on rsp_tvalid. The
// single result channel sets the throughput: the next sample is taken in the
// cycle the previous one issues its last result, so within a table the channel
// runs without gaps unless stalled; the next table's first two samples idle it.
// A job register, a weighted-sum register and the output register form the
// pipeline; a stall on rsp_tready holds all three, and req_tready drops once a
// sample waits in the job register.
// Synchronous reset empties the pipeline and starts a new table.
`default_nettype none

module threefold_quadratic_densifier
   import tqd_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,   // sample, zero padding
   input  wire                                 req_tlast,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]    rsp_tdata,   // value, zero padding
   output logic [1:0]                          rsp_tuser,   // status, run_end
   output logic                                rsp_tlast
);

   localparam int DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int SUM_BITS   = SAMPLE_BITS + WEIGHT_BITS;
   localparam int SHIFT      = SUM_BITS + 3;
   localparam int RECIP_BITS = SHIFT - 2;
   localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
   localparam int QUOT_BITS  = PROD_BITS - SHIFT;
   localparam logic [RECIP_BITS-1:0] RECIP =
      RECIP_BITS'(((64'd1 << SHIFT) + 64'd8) / 64'd9);
   localparam logic [QUOT_BITS-1:0] HALF = QUOT_BITS'(1) << (SAMPLE_BITS - 1);
   localparam logic [SAMPLE_BITS-1:0] MAX_VALUE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] MIN_VALUE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [SAMPLE_BITS-1:0] older_ff, older_in;
   logic signed [SAMPLE_BITS-1:0] newer_ff, newer_in;
   seen_type                      seen_ff, seen_in;

   logic                          job_valid_ff, job_valid_in;
   logic signed [SAMPLE_BITS-1:0] f0_ff, f0_in;
   logic signed [SAMPLE_BITS-1:0] f1_ff, f1_in;
   logic signed [SAMPLE_BITS-1:0] f2_ff, f2_in;
   step_type                      step_ff, step_in;
   step_type                      last_ff, last_in;
   logic                          short_ff, short_in;
   logic                          final_ff, final_in;

   logic                          sum_valid_ff, sum_valid_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic                          sum_status_ff, sum_status_in;
   logic                          sum_run_end_ff, sum_run_end_in;
   logic                          sum_table_end_ff, sum_table_end_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]        value_ff, value_in;
   logic                          status_ff, status_in;
   logic                          run_end_ff, run_end_in;
   logic                          table_end_ff, table_end_in;

   logic                          advance;
   logic                          issue;
   logic                          job_done;
   logic                          accept;
   logic signed [SAMPLE_BITS-1:0] sample;
   weight_set_type                weights;
   logic signed [WEIGHT_BITS-1:0] w0, w1, w2;
   logic [SUM_BITS-1:0]           magnitude;
   logic [SUM_BITS-1:0]           rounded;
   logic [PROD_BITS-1:0]          product;
   logic [QUOT_BITS-1:0]          quotient;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign issue      = job_valid_ff && advance;
   assign job_done   = issue && (step_ff == last_ff);
   assign req_tready = !job_valid_ff || job_done;
   assign accept     = req_tvalid && req_tready;
   assign sample     = $signed(req_tdata[SAMPLE_BITS-1:0]);

   always_comb begin
      older_in     = older_ff;
      newer_in     = newer_ff;
      seen_in      = seen_ff;
      job_valid_in = job_valid_ff;
      f0_in        = f0_ff;
      f1_in        = f1_ff;
      f2_in        = f2_ff;
      step_in      = step_ff;
      last_in      = last_ff;
      short_in     = short_ff;
      final_in     = final_ff;
      if (job_done) begin
         job_valid_in = 1'b0;
      end else if (issue) begin
         step_in = step_ff + step_type'(1);
      end
      if (accept) begin
         if (seen_ff != SEEN_FULL) begin
            if (req_tlast) begin
               job_valid_in = 1'b1;
               step_in      = STEP_OLDER;
               last_in      = LAST_SHORT;
               short_in     = 1'b1;
               final_in     = 1'b1;
               older_in     = '0;
               newer_in     = '0;
               seen_in      = SEEN_NONE;
            end else begin
               older_in = newer_ff;
               newer_in = sample;
               seen_in  = seen_ff + seen_type'(1);
            end
         end else begin
            job_valid_in = 1'b1;
            step_in      = STEP_OLDER;
            last_in      = req_tlast ? LAST_TABLE : LAST_RUN;
            short_in     = 1'b0;
            final_in     = req_tlast;
            f0_in        = older_ff;
            f1_in        = newer_ff;
            f2_in        = sample;
            if (req_tlast) begin
               older_in = '0;
               newer_in = '0;
               seen_in  = SEEN_NONE;
            end else begin
               older_in = newer_ff;
               newer_in = sample;
            end
         end
      end
   end

   always_comb begin
      weights = short_ff ? weight_set_type'('0) : weights_for(step_ff);
      w0 = $signed(weights.w0);
      w1 = $signed(weights.w1);
      w2 = $signed(weights.w2);
      sum_in = SUM_BITS'(w0) * SUM_BITS'(f0_ff)
             + SUM_BITS'(w1) * SUM_BITS'(f1_ff)
             + SUM_BITS'(w2) * SUM_BITS'(f2_ff);
      sum_status_in    = short_ff;
      sum_run_end_in   = (step_ff == last_ff);
      sum_table_end_in = final_ff && (step_ff == last_ff);
      sum_valid_in     = advance ? issue : sum_valid_ff;
   end

   // Divide by nine, rounding to nearest, through a reciprocal multiply.
   always_comb begin
      magnitude = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);
      rounded   = magnitude + SUM_BITS'(4);
      product   = PROD_BITS'(rounded) * PROD_BITS'(RECIP);
      quotient  = product[PROD_BITS-1:SHIFT];
      if (sum_ff[SUM_BITS-1]) begin
         if (quotient > HALF) begin
            value_in = MIN_VALUE;
         end else begin
            value_in = -quotient[SAMPLE_BITS-1:0];
         end
      end else begin
         if (quotient >= HALF) begin
            value_in = MAX_VALUE;
         end else begin
            value_in = quotient[SAMPLE_BITS-1:0];
         end
      end
      status_in    = sum_status_ff;
      run_end_in   = sum_run_end_ff;
      table_end_in = sum_table_end_ff;
      rsp_valid_in = advance ? sum_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff     <= '0;
         newer_ff     <= '0;
         seen_ff      <= SEEN_NONE;
         job_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         older_ff     <= older_in;
         newer_ff     <= newer_in;
         seen_ff      <= seen_in;
         job_valid_ff <= job_valid_in;
         sum_valid_ff <= sum_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      f0_ff    <= f0_in;
      f1_ff    <= f1_in;
      f2_ff    <= f2_in;
      step_ff  <= step_in;
      last_ff  <= last_in;
      short_ff <= short_in;
      final_ff <= final_in;
      if (advance && issue) begin
         sum_ff           <= sum_in;
         sum_status_ff    <= sum_status_in;
         sum_run_end_ff   <= sum_run_end_in;
         sum_table_end_ff <= sum_table_end_in;
      end
      if (advance && sum_valid_ff) begin
         value_ff     <= value_in;
         status_ff    <= status_in;
         run_end_ff   <= run_end_in;
         table_end_ff <= table_end_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'(value_ff);
   assign rsp_tuser  = {run_end_ff, status_ff};
   assign rsp_tlast  = table_end_ff;

`include "threefold_quadratic_densifier_macros.svh"

   `TQD_ASSERT(a_seen_bounded, seen_ff != 2'd3, "sample count passed a full window")
   `TQD_ASSERT_IMPL(a_step_in_job, job_valid_ff, step_ff <= last_ff, "step beyond job end")
   `TQD_ASSERT_IMPL(a_short_single, job_valid_ff && short_ff, last_ff == LAST_SHORT,
      "short table job with more than one result")
   `TQD_ASSERT_IMPL(a_table_end_run_end, rsp_valid_ff && table_end_ff, run_end_ff,
      "table end without run end")
   `TQD_ASSERT_IMPL(a_status_ends_table, rsp_valid_ff && status_ff, table_end_ff,
      "short table result not closing the table")

endmodule

`default_nettype wire

[sim/tb_threefold_quadratic_densifier.sv]
// Self-checking testbench for the threefold quadratic densifier.
`timescale 1ns / 1ps

module tb_threefold_quadratic_densifier
   import tqd_pkg::*;
();

   localparam int SAMPLE_BITS = 16;
   localparam int DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_ITEMS = 33;
   localparam int MAX_PRINTED = 100;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] value;
      logic                   status;
      logic                   run_end;
      logic                   table_end;
   } dense_point_type;

   class densified_table_scoreboard;
      logic signed [SAMPLE_BITS-1:0] older;
      logic signed [SAMPLE_BITS-1:0] newer;
      seen_type held;
      dense_point_type expected_points[$];
      int mismatches;
      int checked;
      int samples;
      int tables;
      int short_tables;

      function new();
         clear_window();
         mismatches = 0;
         checked = 0;
         samples = 0;
         tables = 0;
         short_tables = 0;
      endfunction

      function void clear_window();
         older = '0;
         newer = '0;
         held = SEEN_NONE;
      endfunction

      task report_mismatch(input string msg);
         mismatches++;
         if (mismatches <= MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
         end
      endtask

      function logic [SAMPLE_BITS-1:0] ninths(input int w0, input int w1, input int w2,
                                              input logic signed [SAMPLE_BITS-1:0] s2);
         longint num;
         longint q;
         longint hi;
         longint lo;
         hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
         lo = -hi - 1;
         num = w0 * longint'(older) + w1 * longint'(newer) + w2 * longint'(s2);
         if (num >= 0) begin
            q = (num + 4) / 9;
         end else begin
            q = -((-num + 4) / 9);
         end
         if (q > hi) q = hi;
         if (q < lo) q = lo;
         return SAMPLE_BITS'(q);
      endfunction

      function void push(input logic [SAMPLE_BITS-1:0] value, input logic status,
                         input logic run_end, input logic table_end);
         expected_points.push_back('{value, status, run_end, table_end});
      endfunction

      function void note_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic fin);
         samples++;
         if (held < SEEN_FULL) begin
            if (fin) begin
               push('0, 1'b1, 1'b1, 1'b1);
               tables++;
               short_tables++;
               clear_window();
            end else begin
               older = newer;
               newer = s;
               held = held + 1'b1;
            end
            return;
         end
         push(older, 1'b0, 1'b0, 1'b0);
         push(ninths(5, 5, -1, s), 1'b0, 1'b0, 1'b0);
         if (!fin) begin
            push(ninths(2, 8, -1, s), 1'b0, 1'b1, 1'b0);
            older = newer;
            newer = s;
         end else begin
            push(ninths(2, 8, -1, s), 1'b0, 1'b0, 1'b0);
            push(newer, 1'b0, 1'b0, 1'b0);
            push(ninths(-1, 8, 2, s), 1'b0, 1'b0, 1'b0);
            push(ninths(-1, 5, 5, s), 1'b0, 1'b0, 1'b0);
            push(s, 1'b0, 1'b1, 1'b1);
            tables++;
            clear_window();
         end
      endfunction

      task check_point(input dense_point_type got);
         dense_point_type want;
         checked++;
         if (expected_points.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d status %0b run_end %0b",
                                      $signed(got.value), got.status, got.run_end));
            return;
         end
         want = expected_points.pop_front();
         if (got.value !== want.value) begin
            report_mismatch($sformatf("result %0d value %0d, expected %0d", checked,
                                      $signed(got.value), $signed(want.value)));
         end
         if (got.status !== want.status) begin
            report_mismatch($sformatf("result %0d status %0b, expected %0b", checked,
                                      got.status, want.status));
         end
         if (got.run_end !== want.run_end) begin
            report_mismatch($sformatf("result %0d run_end %0b, expected %0b", checked,
                                      got.run_end, want.run_end));
         end
         if (got.table_end !== want.table_end) begin
            report_mismatch($sformatf("result %0d table_end %0b, expected %0b", checked,
                                      got.table_end, want.table_end));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DATA_BITS-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int cycle_count = 0;
   int phase_items = 0;

   densified_table_scoreboard board = new();

   threefold_quadratic_densifier #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_point('{rsp_tdata[SAMPLE_BITS-1:0], rsp_tuser[0], rsp_tuser[1],
                             rsp_tlast});
      end
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // The valid stays high between back-to-back transactions; it drops only for a gap.
   task automatic send_sample(input int value, input logic fin);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= DATA_BITS'(SAMPLE_BITS'(value));
      req_tlast <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_sample(SAMPLE_BITS'(value), fin);
      phase_items++;
   endtask

   function automatic int random_sample();
      int hi;
      hi = (1 << (SAMPLE_BITS - 1)) - 1;
      case ($urandom_range(0, 9))
         6, 7: return $urandom_range(0, 400) - 200;
         8: return $urandom_range(0, 1) ? hi : -hi - 1;
         9: return $urandom_range(0, 1) ? hi - $urandom_range(0, 15)
                                        : -hi - 1 + $urandom_range(0, 15);
         default: return int'($signed(SAMPLE_BITS'($urandom)));
      endcase
   endfunction

   task automatic send_random_table();
      int length;
      length = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
      for (int i = 0; i < length; i++) begin
         send_sample(random_sample(), i == length - 1);
      end
   endtask

   initial begin : stimulus
      int directed_values [21] = '{
         5,
         -3, 9,
         32767, 32767, -32768, -32768, 32767, 32767,
         0, -1, 1, 5,
         -32768, 32767, -32768,
         -7, 100, -3, 12345, -12345
      };
      bit directed_final [21] = '{
         1,
         0, 1,
         0, 0, 0, 0, 0, 1,
         0, 0, 0, 1,
         0, 0, 1,
         0, 0, 0, 0, 1
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 21; i++) begin
         send_sample(directed_values[i], directed_final[i]);
      end
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
            default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) send_random_table();
      end
      req_tvalid <= 1'b0;
      while (board.expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.expected_points.size() != 0) begin
         board.report_mismatch($sformatf("%0d expected results never arrived",
                                         board.expected_points.size()));
      end
      $display("Streamed %0d samples in %0d tables (%0d too short) under four idle mixes.",
               board.samples, board.tables, board.short_tables);
      $display("Checked %0d results, %0d mismatches.", board.checked, board.mismatches);
      if (board.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
